### sv/mrc_pkg.sv
`default_nettype none

package mrc_pkg;

   // Longest frame in bytes; the byte counter must also hold one past it.
   localparam int MaxFrame   = 256;
   localparam int CountWidth = $clog2(MaxFrame + 2);

   localparam logic [15:0] CrcInit = 16'hFFFF;
   localparam logic [15:0] CrcPoly = 16'hA001;
   localparam logic [7:0]  ByteMax = 8'hFF;

   // Configuration register indexes.
   localparam logic [1:0] CSR_STATION_ADDRESS   = 2'd0;
   localparam logic [1:0] CSR_EXPECTED_FUNCTION = 2'd1;
   localparam logic [1:0] CSR_COMMS_DISABLED    = 2'd2;

   // Function codes that set the length of the response data.
   localparam logic [7:0] FC_READ_COILS         = 8'h01;
   localparam logic [7:0] FC_READ_DISCRETE      = 8'h02;
   localparam logic [7:0] FC_READ_HOLDING       = 8'h03;
   localparam logic [7:0] FC_READ_INPUT         = 8'h04;
   localparam logic [7:0] FC_WRITE_COIL         = 8'h05;
   localparam logic [7:0] FC_WRITE_REGISTER     = 8'h06;
   localparam logic [7:0] FC_GET_EVENT_COUNTER  = 8'h0B;
   localparam logic [7:0] FC_GET_EVENT_LOG      = 8'h0C;
   localparam logic [7:0] FC_WRITE_COILS        = 8'h0F;
   localparam logic [7:0] FC_WRITE_REGISTERS    = 8'h10;
   localparam logic [7:0] FC_REPORT_SERVER_ID   = 8'h11;
   localparam logic [7:0] FC_READ_FILE          = 8'h14;
   localparam logic [7:0] FC_WRITE_FILE         = 8'h15;
   localparam logic [7:0] FC_MASK_WRITE         = 8'h16;
   localparam logic [7:0] FC_READ_WRITE_MULTI   = 8'h17;
   localparam logic [7:0] FC_READ_FIFO          = 8'h18;

   typedef enum logic [2:0] {
      STATUS_OK       = 3'd0,
      STATUS_LENGTH   = 3'd1,
      STATUS_CRC      = 3'd2,
      STATUS_ADDRESS  = 3'd3,
      STATUS_FUNCTION = 3'd4,
      STATUS_DISABLED = 3'd5,
      STATUS_OVERFLOW = 3'd6
   } status_type;

   typedef struct packed {
      logic [7:0] station_address;
      logic [6:0] expected_function;
      logic       comms_disabled;
   } cfg_type;

   typedef struct packed {
      logic [8:0] frame_bytes;
      logic [7:0] data_length;
      logic       is_exception;
      logic [6:0] frame_function;
      logic [7:0] frame_address;
      status_type status;
   } result_type;

   // One byte of the reflected Modbus CRC-16, bit by bit.
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

### sv/modbus_rtu_response_checker_unit.sv
// Modbus RTU response checker for the master side of a serial link.
// The req channel carries one item per received character: req_tuser low
// means req_tdata is a received byte, req_tuser high is a clear command that
// marks a frame start or an inter-frame timeout and gives no result.
// The rsp channel carries one status item when a frame completes (by the
// length the function code implies), overflows, or fails a check. After any
// failure, bytes are dropped until the next clear command.
// The csr port writes station address, expected function and the disable
// flag; write it only while no item is in flight.
// An accepted item waits in the input register until the result register can
// take a result; it is then checked and its result is registered for rsp_tvalid.
// Throughput: one item per clock while results are taken. The byte-wise CRC
// update, length decode and checks all sit between the input register and
// the result register. If the receiver stalls, the result register holds and
// the input register fills; req_tready then drops until the result is taken.
// Reset clears the frame state, loads the register defaults (address 1,
// function 3, enabled) and empties both registers.

`default_nettype none

module modbus_rtu_response_checker_unit
   import mrc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // Input items.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,  // [7:0] rx_byte
   input  wire logic        req_tuser,  // [0] cmd
   // Result items.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [2:0] status, [10:3] frame_address, [17:11] frame_function,
   // [18] is_exception, [26:19] data_length, [35:27] frame_bytes, [39:36] zero
   output logic [39:0]      rsp_tdata,
   // Configuration writes.
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);

   logic       in_valid_ff, in_valid_in;
   logic       in_cmd_ff;
   logic [7:0] in_byte_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;
   cfg_type    cfg_ff;

   logic       out_free, step, accept, core_emit;
   result_type core_result;

   // The checker advances only when the result register can take a result.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign accept     = req_tvalid && req_tready;

   assign in_valid_in  = accept ? 1'b1 : (step ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = out_free ? (step && core_emit) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_cmd_ff  <= req_tuser;
         in_byte_ff <= req_tdata;
      end
      if (step && core_emit) begin
         rsp_data_ff <= core_result;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.station_address   <= 8'd1;
         cfg_ff.expected_function <= 7'd3;
         cfg_ff.comms_disabled    <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_STATION_ADDRESS:   cfg_ff.station_address   <= csr_wdata;
            CSR_EXPECTED_FUNCTION: cfg_ff.expected_function <= csr_wdata[6:0];
            CSR_COMMS_DISABLED:    cfg_ff.comms_disabled    <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   mrc_frame_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .cmd     (in_cmd_ff),
      .rx_byte (in_byte_ff),
      .cfg     (cfg_ff),
      .emit    (core_emit),
      .result  (core_result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_data_ff};

   // A slot that frees without a new result leaves the output empty.
   a_no_phantom_result : assert property (@(posedge clock) disable iff (reset)
      (out_free && !(step && core_emit)) |=> !rsp_tvalid)
      else $error("result appeared without a completed frame");

   // A clear command never produces a result.
   a_clear_silent : assert property (@(posedge clock) disable iff (reset)
      (step && in_cmd_ff) |-> !core_emit)
      else $error("clear command produced a result");

   // An overflow is reported exactly one byte past the longest frame.
   a_overflow_count : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status == STATUS_OVERFLOW)
         |-> (rsp_data_ff.frame_bytes == 9'(MaxFrame + 1)))
      else $error("overflow reported at wrong byte count");

   // A good frame carries the configured address and function.
   a_ok_matches_cfg : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status == STATUS_OK)
         |-> (rsp_data_ff.frame_address == cfg_ff.station_address &&
              rsp_data_ff.frame_function == cfg_ff.expected_function &&
              !cfg_ff.comms_disabled))
      else $error("good status on a frame that does not match the configuration");

endmodule

`default_nettype wire

### sv/mrc_len_decode.sv
`default_nettype none

module mrc_len_decode
   import mrc_pkg::*;
(
   input  wire logic [7:0] func_byte,
   input  wire logic [7:0] data0,
   input  wire logic [7:0] data1,
   output logic      [8:0] exp_len,
   output logic            open_len
);

   always_comb begin
      exp_len  = 9'd0;
      open_len = 1'b0;
      if (func_byte[7]) begin
         exp_len = 9'd1;
      end else begin
         unique case (func_byte)
            FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT,
            FC_GET_EVENT_LOG, FC_REPORT_SERVER_ID, FC_READ_FILE, FC_WRITE_FILE,
            FC_READ_WRITE_MULTI: begin
               exp_len = {1'b0, data0} + 9'd1;
            end
            FC_WRITE_COIL, FC_WRITE_REGISTER, FC_GET_EVENT_COUNTER,
            FC_WRITE_COILS, FC_WRITE_REGISTERS: begin
               exp_len = 9'd4;
            end
            FC_MASK_WRITE: begin
               exp_len = 9'd6;
            end
            FC_READ_FIFO: begin
               exp_len = {1'b0, data1} + 9'd2;
            end
            default: begin
               // Unknown function: the frame ends with whatever has arrived.
               open_len = 1'b1;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

### sv/mrc_frame_core.sv
`default_nettype none

module mrc_frame_core
   import mrc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic       cmd,
   input  wire logic [7:0] rx_byte,
   input  wire cfg_type    cfg,
   output logic            emit,
   output result_type      result
);

   logic [CountWidth-1:0] count_ff, count_in, count_nx;
   logic [15:0]           crc_ff, crc_in, crc_upd;
   logic [7:0]            d0_ff, d0_in, d1_ff, d1_in;
   logic [7:0]            hdr_ff [4];
   logic [7:0]            hdr_in [4];
   logic [7:0]            hdr_nx [4];
   logic                  flush_ff, flush_in;

   logic [8:0]            exp_len, exp_eff, got, dlen_src;
   logic                  open_len, overflow, crc_bad;
   status_type            status;

   // The CRC trails the input by two bytes so that it covers all but the
   // received CRC once the frame is complete.
   assign crc_upd  = (count_ff >= CountWidth'(2)) ? crc16_byte(crc_ff, d0_ff) : crc_ff;
   assign count_nx = count_ff + CountWidth'(1);

   for (genvar i = 0; i < 4; i++) begin : g_hdr
      assign hdr_nx[i] = (count_ff == CountWidth'(i)) ? rx_byte : hdr_ff[i];
   end

   mrc_len_decode u_len (
      .func_byte (hdr_nx[1]),
      .data0     (hdr_nx[2]),
      .data1     (hdr_nx[3]),
      .exp_len   (exp_len),
      .open_len  (open_len)
   );

   assign got      = 9'(count_nx - CountWidth'(4));
   assign exp_eff  = open_len ? got : exp_len;
   assign overflow = count_nx > CountWidth'(MaxFrame);
   assign crc_bad  = (crc_upd[7:0] != d1_ff) || (crc_upd[15:8] != rx_byte);
   assign dlen_src = overflow ? exp_eff : got;

   always_comb begin
      priority if (overflow) begin
         status = STATUS_OVERFLOW;
      end else if (got > exp_eff) begin
         status = STATUS_LENGTH;
      end else if (crc_bad) begin
         status = STATUS_CRC;
      end else if (hdr_nx[0] != cfg.station_address) begin
         status = STATUS_ADDRESS;
      end else if (hdr_nx[1][6:0] != cfg.expected_function) begin
         status = STATUS_FUNCTION;
      end else if (cfg.comms_disabled) begin
         status = STATUS_DISABLED;
      end else begin
         status = STATUS_OK;
      end
   end

   assign emit = step && !cmd && !flush_ff &&
                 (overflow || (count_nx >= CountWidth'(4) && got >= exp_eff));

   assign result.status         = status;
   assign result.frame_address  = hdr_nx[0];
   assign result.frame_function = hdr_nx[1][6:0];
   assign result.is_exception   = hdr_nx[1][7];
   assign result.data_length    = (dlen_src > {1'b0, ByteMax}) ? ByteMax : dlen_src[7:0];
   assign result.frame_bytes    = 9'(count_nx);

   always_comb begin
      count_in = count_ff;
      crc_in   = crc_ff;
      d0_in    = d0_ff;
      d1_in    = d1_ff;
      hdr_in   = hdr_ff;
      flush_in = flush_ff;
      if (step) begin
         if (cmd) begin
            count_in = '0;
            crc_in   = CrcInit;
            d0_in    = 8'h00;
            d1_in    = 8'h00;
            hdr_in   = '{default: 8'h00};
            flush_in = 1'b0;
         end else if (!flush_ff) begin
            count_in = count_nx;
            crc_in   = crc_upd;
            d0_in    = d1_ff;
            d1_in    = rx_byte;
            hdr_in   = hdr_nx;
            if (emit) begin
               if (status == STATUS_OK) begin
                  // A good frame readies the checker for the next one.
                  count_in = '0;
                  crc_in   = CrcInit;
                  d0_in    = 8'h00;
                  d1_in    = 8'h00;
                  hdr_in   = '{default: 8'h00};
               end else begin
                  flush_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         crc_ff   <= CrcInit;
         d0_ff    <= 8'h00;
         d1_ff    <= 8'h00;
         hdr_ff   <= '{default: 8'h00};
         flush_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         crc_ff   <= crc_in;
         d0_ff    <= d0_in;
         d1_ff    <= d1_in;
         hdr_ff   <= hdr_in;
         flush_ff <= flush_in;
      end
   end

endmodule

`default_nettype wire
